FILE: rtl/stpb_pkg.sv
package stpb_pkg;

    // item kinds
    localparam logic [1:0] KIND_POSE    = 2'd0;
    localparam logic [1:0] KIND_CAPTURE = 2'd1;
    localparam logic [1:0] KIND_REMOVE  = 2'd2;
    localparam logic [1:0] KIND_IGNORE  = 2'd3;

    // result status codes
    localparam logic [2:0] ST_STORED  = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_STALE   = 3'd2;
    localparam logic [2:0] ST_BAD_ORI = 3'd3;
    localparam logic [2:0] ST_POSE    = 3'd4;
    localparam logic [2:0] ST_REMOVED = 3'd5;
    localparam logic [2:0] ST_NONE    = 3'd6;

    // configuration register indexes
    localparam logic CFG_POINTS_NEEDED = 1'b0;
    localparam logic CFG_MAX_POSE_AGE  = 1'b1;

    localparam logic [6:0]  POINTS_NEEDED_RST = 7'd4;
    localparam logic [15:0] MAX_POSE_AGE_RST  = 16'd250;

    // one classified item, front to back
    typedef struct packed {
        logic [2:0]         status;
        logic [6:0]         count;
        logic signed [24:0] rx;
        logic signed [24:0] ry;
        logic signed [24:0] rz;
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
    } t_job;

    // queue read side
    typedef struct packed {
        logic valid;
        t_job job;
    } t_qhead;

endpackage

FILE: rtl/stpb_queue.sv
module stpb_queue import stpb_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_job   i_job,
    output logic   o_full,
    input  logic   i_pop,
    output t_qhead o_head
);

    t_job       r_ent [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full       = (r_cnt == 2'd2);
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.job   = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_ent[r_wp] <= i_job;
                r_wp        <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: rtl/stpb_front.sv
module stpb_front import stpb_pkg::*; #(
    parameter int MAX_POINTS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_idx,
    input  logic [15:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_kind,
    input  logic [31:0]        i_stamp_ms,
    input  logic signed [23:0] i_pos_x,
    input  logic signed [23:0] i_pos_y,
    input  logic signed [23:0] i_pos_z,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    input  logic signed [15:0] i_quat_w,
    input  logic               i_q_full,
    output logic               o_push,
    output t_job               o_job
);

    logic [6:0]         r_points_needed;
    logic [15:0]        r_max_pose_age;
    logic signed [23:0] r_bx, r_by, r_bz;
    logic signed [15:0] r_qx, r_qy, r_qz, r_qw;
    logic [31:0]        r_stamp;
    logic [6:0]         r_count;

    logic        accept;
    logic [31:0] age;
    logic        stale;
    logic        full;
    logic        in_qzero;
    logic        st_qzero;
    logic [2:0]  n_status;
    logic [6:0]  n_count;
    logic        take_pose;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign o_push     = accept && (i_kind != KIND_IGNORE);

    assign age      = i_stamp_ms - r_stamp;
    assign stale    = $signed(age) > $signed({16'd0, r_max_pose_age});
    assign full     = (r_count >= r_points_needed) || ({25'd0, r_count} >= 32'(MAX_POINTS));
    assign in_qzero = (i_quat_x == 16'sd0) && (i_quat_y == 16'sd0) &&
                      (i_quat_z == 16'sd0) && (i_quat_w == 16'sd0);
    assign st_qzero = (r_qx == 16'sd0) && (r_qy == 16'sd0) &&
                      (r_qz == 16'sd0) && (r_qw == 16'sd0);

    always_comb begin
        n_status  = ST_NONE;
        n_count   = r_count;
        take_pose = 1'b0;
        case (i_kind)
            KIND_POSE: begin
                if (in_qzero) begin
                    n_status = ST_BAD_ORI;
                end else begin
                    n_status  = ST_POSE;
                    take_pose = 1'b1;
                end
            end
            KIND_CAPTURE: begin
                if (full) begin
                    n_status = ST_FULL;
                end else if (stale) begin
                    n_status = ST_STALE;
                end else if (st_qzero) begin
                    n_status = ST_BAD_ORI;
                end else begin
                    n_status = ST_STORED;
                    n_count  = r_count + 7'd1;
                end
            end
            KIND_REMOVE: begin
                if (r_count != 7'd0) begin
                    n_status = ST_REMOVED;
                    n_count  = r_count - 7'd1;
                end else begin
                    n_status = ST_NONE;
                end
            end
            default: begin
                n_status = ST_NONE;
            end
        endcase
    end

    assign o_job.status = n_status;
    assign o_job.count  = n_count;
    assign o_job.rx     = {i_pos_x[23], i_pos_x} - {r_bx[23], r_bx};
    assign o_job.ry     = {i_pos_y[23], i_pos_y} - {r_by[23], r_by};
    assign o_job.rz     = {i_pos_z[23], i_pos_z} - {r_bz[23], r_bz};
    assign o_job.qx     = r_qx;
    assign o_job.qy     = r_qy;
    assign o_job.qz     = r_qz;
    assign o_job.qw     = r_qw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points_needed <= POINTS_NEEDED_RST;
            r_max_pose_age  <= MAX_POSE_AGE_RST;
            r_bx            <= '0;
            r_by            <= '0;
            r_bz            <= '0;
            r_qx            <= '0;
            r_qy            <= '0;
            r_qz            <= '0;
            r_qw            <= '0;
            r_stamp         <= '0;
            r_count         <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    CFG_POINTS_NEEDED: r_points_needed <= i_cfg_wdata[6:0];
                    CFG_MAX_POSE_AGE:  r_max_pose_age  <= i_cfg_wdata;
                    default:           r_max_pose_age  <= r_max_pose_age;
                endcase
            end
            if (o_push) begin
                r_count <= n_count;
                if (take_pose) begin
                    r_bx    <= i_pos_x;
                    r_by    <= i_pos_y;
                    r_bz    <= i_pos_z;
                    r_qx    <= i_quat_x;
                    r_qy    <= i_quat_y;
                    r_qz    <= i_quat_z;
                    r_qw    <= i_quat_w;
                    r_stamp <= i_stamp_ms;
                end
            end
        end
    end

endmodule

FILE: rtl/stpb_back.sv
module stpb_back import stpb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_qhead             i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_status,
    output logic [6:0]         o_point_count,
    output logic signed [23:0] o_local_x,
    output logic signed [23:0] o_local_y,
    output logic signed [23:0] o_local_z
);

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_PREP, S_DIV, S_FIN} t_state;

    t_state             r_state;
    logic [4:0]         r_k;
    logic               r_pv;
    logic [4:0]         r_ptag;
    logic signed [58:0] r_prod;
    logic signed [31:0] r_qp  [10];
    logic signed [59:0] r_acc [3];
    logic [58:0]        r_rem [3];
    logic [25:0]        r_quo [3];
    logic [57:0]        r_dsr;
    t_job               r_job;

    logic signed [33:0] t_m [3][3];
    logic [32:0]        norm;
    logic signed [33:0] op_a;
    logic signed [24:0] op_b;
    logic signed [58:0] n_prod;
    logic [3:0]         issue_j;
    logic [3:0]         issue_rc;
    logic [3:0]         proc_j;
    logic [3:0]         proc_rc;
    logic [3:0]         qsel;

    // quaternion parts: 0 scalar, 1 x, 2 y, 3 z
    function automatic logic signed [15:0] quat_part(input t_job j, input logic [1:0] s);
        logic signed [15:0] v;
        case (s)
            2'd0:    v = j.qw;
            2'd1:    v = j.qx;
            2'd2:    v = j.qy;
            default: v = j.qz;
        endcase
        return v;
    endfunction

    // product schedule: aa bb cc dd ab ac ad bc bd cd
    function automatic logic [3:0] pair_sel(input logic [3:0] k);
        logic [3:0] p;
        case (k)
            4'd0:    p = 4'b00_00;
            4'd1:    p = 4'b01_01;
            4'd2:    p = 4'b10_10;
            4'd3:    p = 4'b11_11;
            4'd4:    p = 4'b00_01;
            4'd5:    p = 4'b00_10;
            4'd6:    p = 4'b00_11;
            4'd7:    p = 4'b01_10;
            4'd8:    p = 4'b01_11;
            default: p = 4'b10_11;
        endcase
        return p;
    endfunction

    // matrix step to {row, col}
    function automatic logic [3:0] row_col(input logic [3:0] j);
        logic [3:0] rc;
        case (j)
            4'd0:    rc = 4'b00_00;
            4'd1:    rc = 4'b00_01;
            4'd2:    rc = 4'b00_10;
            4'd3:    rc = 4'b01_00;
            4'd4:    rc = 4'b01_01;
            4'd5:    rc = 4'b01_10;
            4'd6:    rc = 4'b10_00;
            4'd7:    rc = 4'b10_01;
            default: rc = 4'b10_10;
        endcase
        return rc;
    endfunction

    function automatic logic signed [33:0] sx(input logic signed [31:0] v);
        return {{2{v[31]}}, v};
    endfunction

    function automatic logic signed [24:0] rvec(input t_job j, input logic [1:0] c);
        logic signed [24:0] v;
        case (c)
            2'd0:    v = j.rx;
            2'd1:    v = j.ry;
            default: v = j.rz;
        endcase
        return v;
    endfunction

    function automatic logic [23:0] sat_out(input logic neg, input logic [25:0] q);
        logic [25:0] nq;
        logic [23:0] v;
        nq = ~q + 26'd1;
        if (neg) begin
            v = (q > 26'd8388608) ? 24'h800000 : nq[23:0];
        end else begin
            v = (q > 26'd8388607) ? 24'h7FFFFF : q[23:0];
        end
        return v;
    endfunction

    // scaled transpose of the rotation
    always_comb begin
        t_m[0][0] = sx(r_qp[0]) + sx(r_qp[1]) - sx(r_qp[2]) - sx(r_qp[3]);
        t_m[0][1] = (sx(r_qp[6]) + sx(r_qp[7])) <<< 1;
        t_m[0][2] = (sx(r_qp[8]) - sx(r_qp[5])) <<< 1;
        t_m[1][0] = (sx(r_qp[7]) - sx(r_qp[6])) <<< 1;
        t_m[1][1] = sx(r_qp[0]) - sx(r_qp[1]) + sx(r_qp[2]) - sx(r_qp[3]);
        t_m[1][2] = (sx(r_qp[4]) + sx(r_qp[9])) <<< 1;
        t_m[2][0] = (sx(r_qp[5]) + sx(r_qp[8])) <<< 1;
        t_m[2][1] = (sx(r_qp[9]) - sx(r_qp[4])) <<< 1;
        t_m[2][2] = sx(r_qp[0]) - sx(r_qp[1]) - sx(r_qp[2]) + sx(r_qp[3]);
    end

    assign norm = {1'b0, r_qp[0]} + {1'b0, r_qp[1]} + {1'b0, r_qp[2]} + {1'b0, r_qp[3]};

    assign issue_j  = r_k[3:0] - 4'd11;
    assign issue_rc = row_col(issue_j);
    assign proc_j   = r_ptag[3:0] - 4'd11;
    assign proc_rc  = row_col(proc_j);
    assign qsel     = pair_sel(r_k[3:0]);

    always_comb begin
        op_a = '0;
        op_b = '0;
        if (r_k < 5'd10) begin
            op_a = 34'(quat_part(r_job, qsel[3:2]));
            op_b = 25'(quat_part(r_job, qsel[1:0]));
        end else if (r_k >= 5'd11 && r_k <= 5'd19) begin
            op_a = t_m[issue_rc[3:2]][issue_rc[1:0]];
            op_b = rvec(r_job, issue_rc[1:0]);
        end
    end

    assign n_prod = op_a * op_b;
    assign o_pop  = (r_state == S_IDLE) && i_head.valid && !o_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_pv        <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_pv <= 1'b0;
                    if (o_pop) begin
                        r_job <= i_head.job;
                        if (i_head.job.status == ST_STORED) begin
                            r_k      <= '0;
                            r_acc[0] <= '0;
                            r_acc[1] <= '0;
                            r_acc[2] <= '0;
                            r_state  <= S_MUL;
                        end else begin
                            o_status      <= i_head.job.status;
                            o_point_count <= i_head.job.count;
                            o_local_x     <= '0;
                            o_local_y     <= '0;
                            o_local_z     <= '0;
                            o_out_valid   <= 1'b1;
                        end
                    end
                end
                S_MUL: begin
                    r_prod <= n_prod;
                    r_ptag <= r_k;
                    r_pv   <= (r_k != 5'd10) && (r_k != 5'd20);
                    // retire last cycle's product
                    if (r_pv) begin
                        if (r_ptag < 5'd10) begin
                            r_qp[r_ptag[3:0]] <= r_prod[31:0];
                        end else begin
                            r_acc[proc_rc[3:2]] <= r_acc[proc_rc[3:2]] + 60'(r_prod);
                        end
                    end
                    if (r_k == 5'd20) begin
                        r_state <= S_PREP;
                    end else begin
                        r_k <= r_k + 5'd1;
                    end
                end
                S_PREP: begin
                    r_pv <= 1'b0;
                    for (int i = 0; i < 3; i++) begin
                        r_rem[i] <= r_acc[i][59] ? 59'(-r_acc[i]) : 59'(r_acc[i]);
                        r_quo[i] <= '0;
                    end
                    r_dsr   <= {norm[32:0], 25'd0};
                    r_k     <= 5'd25;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    for (int i = 0; i < 3; i++) begin
                        if (r_rem[i] >= {1'b0, r_dsr}) begin
                            r_rem[i] <= r_rem[i] - {1'b0, r_dsr};
                            r_quo[i] <= {r_quo[i][24:0], 1'b1};
                        end else begin
                            r_quo[i] <= {r_quo[i][24:0], 1'b0};
                        end
                    end
                    r_dsr <= r_dsr >> 1;
                    if (r_k == 5'd0) begin
                        r_state <= S_FIN;
                    end else begin
                        r_k <= r_k - 5'd1;
                    end
                end
                S_FIN: begin
                    o_status      <= ST_STORED;
                    o_point_count <= r_job.count;
                    o_local_x     <= sat_out(r_acc[0][59], r_quo[0]);
                    o_local_y     <= sat_out(r_acc[1][59], r_quo[1]);
                    o_local_z     <= sat_out(r_acc[2][59], r_quo[2]);
                    o_out_valid   <= 1'b1;
                    r_state       <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/stylus_point_to_body_frame.sv
// Flow: pose, remove and rejected captures pass the queue register, then the output register;
//   a stored capture is popped, then runs the product sequence on the shared multiplier,
//   a setup state, the 26-step restoring divider and a finish state.
// The back pops no new job until the current one is finished and the output register has
//   drained; meanwhile the 2-entry queue lets the front keep taking transfers.
// Reset (synchronous, active low): clears pose, count and queue; points_needed = 4,
//   max_pose_age = 250.
module stylus_point_to_body_frame import stpb_pkg::*; #(
    parameter int MAX_POINTS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_idx,
    input  logic [15:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_kind,
    input  logic [31:0]        i_stamp_ms,
    input  logic signed [23:0] i_pos_x,
    input  logic signed [23:0] i_pos_y,
    input  logic signed [23:0] i_pos_z,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    input  logic signed [15:0] i_quat_w,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_status,
    output logic [6:0]         o_point_count,
    output logic signed [23:0] o_local_x,
    output logic signed [23:0] o_local_y,
    output logic signed [23:0] o_local_z
);

    // front: classify each transfer, own the pose and point count
    logic   q_full;
    logic   push;
    t_job   job;
    // back: pull jobs, run the transform for stored captures
    t_qhead head;
    logic   pop;

    stpb_front #(.MAX_POINTS(MAX_POINTS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_stamp_ms  (i_stamp_ms),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_pos_z     (i_pos_z),
        .i_quat_x    (i_quat_x),
        .i_quat_y    (i_quat_y),
        .i_quat_z    (i_quat_z),
        .i_quat_w    (i_quat_w),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_job       (job)
    );

    // hold classified jobs so the front keeps taking transfers while the back computes
    stpb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_head  (head)
    );

    stpb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_point_count (o_point_count),
        .o_local_x     (o_local_x),
        .o_local_y     (o_local_y),
        .o_local_z     (o_local_z)
    );

endmodule

FILE: rtl/stpb_checker.sv
module stpb_checker import stpb_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [2:0]         o_status,
    input logic [6:0]         o_point_count,
    input logic signed [23:0] o_local_x,
    input logic signed [23:0] o_local_y,
    input logic signed [23:0] o_local_z
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("output or queue not empty after reset");

    a_zero_unless_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_STORED) |->
            (o_local_x == 24'sd0) && (o_local_y == 24'sd0) && (o_local_z == 24'sd0))
        else $error("nonzero point on a non-stored result");

    a_none_means_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_NONE) |-> (o_point_count == 7'd0))
        else $error("nothing to remove with a nonzero count");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_status) && $stable(o_local_x))
        else $error("stalled result changed");

endmodule

bind stylus_point_to_body_frame stpb_checker u_stpb_checker (.*);
